/* hdl/led_blink_code_sequencer_unit_defines.svh */
// ============================================================================
// LED blink-code sequencer: assertion macros
// Shared concurrent assertion forms for the checker of the sequencer.
// ============================================================================
`ifndef LED_BLINK_CODE_SEQUENCER_UNIT_DEFINES_SVH
`define LED_BLINK_CODE_SEQUENCER_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define LBCS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define LBCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/lbcs_pkg.sv */
// ============================================================================
// LED blink-code sequencer package
// Constants, operation codes and the sequencer state type.
// ============================================================================
package lbcs_pkg;

  // Pattern sizing
  localparam int MAX_INTERVALS = 100;
  localparam int BLINK_CAP     = (MAX_INTERVALS - 2) / 2;

  // Image codes and interval lengths in 100 Hz ticks
  localparam logic [7:0] NO_IMAGE  = 8'hFF;
  localparam logic [7:0] IDLE_LEN  = 8'd50;
  localparam logic [7:0] BLINK_LEN = 8'd20;
  localparam logic [7:0] LAST_LEN  = 8'd200;
  localparam logic [7:0] LEAD_LEN  = 8'd1;

  // Register map (index taken from paddr[2])
  localparam logic REG_IMAGE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_BUTTON = 2'd1,
    OP_LOAD   = 2'd2,
    OP_SELECT = 2'd3
  } lbcs_op_e;

  typedef struct packed {
    logic [7:0] tick_cnt;
    logic [6:0] pos;
    logic [7:0] ilen;
    logic [6:0] plen;
    logic [7:0] cur_image;
    logic [5:0] nxt_image;
  } lbcs_state_t;

endpackage

/* hdl/lbcs_step.sv */
// ============================================================================
// LED blink-code sequencer: step logic
// Next pattern state for one event beat, computed in a single pass.
// ============================================================================
module lbcs_step import lbcs_pkg::*; (
  input  lbcs_state_t state_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  image_number_i,
  input  logic [5:0]  image_count_i,
  output lbcs_state_t state_o
);

  localparam logic [7:0] CAP_W = 8'(BLINK_CAP);

  // Length of interval idx for a given loaded image, selection and pattern length
  function automatic logic [7:0] interval_len(logic [6:0] idx, logic [7:0] cur,
                                              logic [5:0] nxt, logic [6:0] plen);
    logic [7:0] len;
    len = BLINK_LEN;
    if (cur == NO_IMAGE) begin
      len = IDLE_LEN;
    end else if ((cur != {2'b00, nxt}) && (idx == 7'd0)) begin
      len = LEAD_LEN;
    end else if ((idx + 7'd1) == plen) begin
      len = LAST_LEN;
    end
    return len;
  endfunction

  // Restart the pattern at interval zero
  function automatic lbcs_state_t rebuild(lbcs_state_t s);
    lbcs_state_t r;
    logic        lead;
    logic [7:0]  blinks;
    r      = s;
    r.pos  = 7'd0;
    lead   = s.cur_image != {2'b00, s.nxt_image};
    blinks = (s.cur_image >= CAP_W) ? CAP_W : (s.cur_image + 8'd1);
    if (s.cur_image == NO_IMAGE) begin
      r.plen = 7'd2;
      r.ilen = IDLE_LEN;
    end else begin
      r.plen     = 7'({blinks[6:0], 1'b0} + {6'd0, lead});
      r.ilen     = interval_len(7'd0, s.cur_image, s.nxt_image, r.plen);
      r.tick_cnt = 8'd0;
    end
    return r;
  endfunction

  lbcs_op_e    op;
  logic [7:0]  tick_inc;
  logic [6:0]  pos_inc;
  logic [6:0]  nxt_inc;
  lbcs_state_t sel_st;

  assign op       = lbcs_op_e'(op_i);
  assign tick_inc = state_i.tick_cnt + 8'd1;
  assign pos_inc  = state_i.pos + 7'd1;
  assign nxt_inc  = {1'b0, state_i.nxt_image} + 7'd1;

  // Event decode
  always_comb begin
    state_o = state_i;
    sel_st  = state_i;
    unique case (op)
      OP_TICK: begin
        if (tick_inc >= state_i.ilen) begin
          state_o.pos      = (pos_inc >= state_i.plen) ? 7'd0 : pos_inc;
          state_o.ilen     = interval_len(state_o.pos, state_i.cur_image,
                                          state_i.nxt_image, state_i.plen);
          state_o.tick_cnt = 8'd0;
        end else begin
          state_o.tick_cnt = tick_inc;
        end
      end
      OP_BUTTON: begin
        sel_st.nxt_image = (nxt_inc >= {1'b0, image_count_i}) ? 6'd0 : nxt_inc[5:0];
        state_o          = rebuild(sel_st);
      end
      OP_LOAD: begin
        sel_st.cur_image = {2'b00, state_i.nxt_image};
        state_o          = rebuild(sel_st);
      end
      OP_SELECT: begin
        sel_st.nxt_image = (image_number_i >= {2'b00, image_count_i}) ? 6'd0 :
                           image_number_i[5:0];
        state_o          = rebuild(sel_st);
      end
      default: state_o = state_i;
    endcase
  end

endmodule

/* hdl/led_blink_code_sequencer_unit.sv */
// ============================================================================
// LED blink-code sequencer
// Keeps loaded and selected image numbers and steps the LED blink pattern
// on tick, button, load and select event beats.
// ============================================================================
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   event in | in_valid_i / in_ready_o    | op_i, image_number_i
//   result   | out_valid_o / out_ready_i  | led_on_o, interval_index_o,
//            |                            | selected_image_o, loaded_image_o
//   config   | APB psel/penable/pwrite    | paddr, pwdata, prdata (image_count)
//
// One beat per cycle sustained while out_ready_i does not stall the result; a
// beat's result is offered once it has passed the input register and then the
// state/result register.
// The input register takes a new beat while a result waits to be taken.
// Reset clears the pattern to the no-image blink (50 on, 50 off) and
// image_count to zero; no clearing pass is needed.
// ============================================================================
module led_blink_code_sequencer_unit import lbcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  image_number_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        led_on_o,
  output logic [6:0]  interval_index_o,
  output logic [5:0]  selected_image_o,
  output logic [7:0]  loaded_image_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_valid_q, in_valid_d;
  logic [1:0]  op_q;
  logic [7:0]  num_q;
  logic        out_valid_q, out_valid_d;
  logic [5:0]  image_count_q;
  lbcs_state_t state_q, state_d;
  logic        in_fire, advance, cfg_wr;

  // Handshake
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_i;
      num_q <= image_number_i;
    end
  end

  // Step logic
  lbcs_step u_step (
    .state_i        (state_q),
    .op_i           (op_q),
    .image_number_i (num_q),
    .image_count_i  (image_count_q),
    .state_o        (state_d)
  );

  // Pattern state, which is also the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q       <= 1'b0;
      state_q.tick_cnt  <= 8'd0;
      state_q.pos       <= 7'd0;
      state_q.ilen      <= IDLE_LEN;
      state_q.plen      <= 7'd2;
      state_q.cur_image <= NO_IMAGE;
      state_q.nxt_image <= 6'd0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign led_on_o         = !state_q.pos[0];
  assign interval_index_o = state_q.pos;
  assign selected_image_o = state_q.nxt_image;
  assign loaded_image_o   = state_q.cur_image;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IMAGE_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_count_q <= 6'd0;
    end else if (cfg_wr) begin
      image_count_q <= pwdata[5:0];
    end
  end

  assign prdata = (paddr[2] == REG_IMAGE_COUNT) ? {26'd0, image_count_q} : 32'd0;

endmodule

/* hdl/lbcs_checker.sv */
// ============================================================================
// LED blink-code sequencer checker
// Port-level assertions on the result channel, bound to the top level.
// ============================================================================
`include "led_blink_code_sequencer_unit_defines.svh"

module lbcs_checker import lbcs_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       led_on_o,
  input logic [6:0] interval_index_o,
  input logic [5:0] selected_image_o,
  input logic [7:0] loaded_image_o
);

  localparam logic [6:0] MAX_IDX = 7'(MAX_INTERVALS);

  logic [21:0] res_beat;

  assign res_beat = {led_on_o, interval_index_o, selected_image_o, loaded_image_o};

  // A stalled result beat stays and holds its payload
  `LBCS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_beat), "result beat dropped or changed under stall")

  // LED is lit exactly on even intervals
  `LBCS_ASSERT(a_led_phase, clk_i, rst_ni, out_valid_o |-> led_on_o == !interval_index_o[0], "LED phase does not follow interval index")

  // Interval index stays below MAX_INTERVALS, the largest pattern size
  `LBCS_ASSERT(a_idx_range, clk_i, rst_ni, out_valid_o |-> interval_index_o < MAX_IDX, "interval index beyond pattern size")

  // Loaded image is either none or a six-bit selection
  `LBCS_ASSERT(a_loaded_code, clk_i, rst_ni, loaded_image_o == NO_IMAGE || loaded_image_o[7:6] == 2'b00, "loaded image code out of range")

  // No result beat is offered right after a reset edge
  `LBCS_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind led_blink_code_sequencer_unit lbcs_checker u_lbcs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .led_on_o         (led_on_o),
  .interval_index_o (interval_index_o),
  .selected_image_o (selected_image_o),
  .loaded_image_o   (loaded_image_o)
);
